FILE: sv/can_signal_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// CAN signal stream decoder assertion macros
// Clocked assertion wrappers for the checker file of the decoder.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_STREAM_DECODER_MACROS_SVH
`define CAN_SIGNAL_STREAM_DECODER_MACROS_SVH

// Checked only while the block is out of reset.
`define CSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define CSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/csd_pkg.sv
// ----------------------------------------------------------------------------
// CAN signal stream decoder package
// Shared constants, command codes and record types of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

  localparam int unsigned NUM_STREAMS = 8;
  localparam int unsigned SLOT_IW     = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] ORDER_LSB0     = 2'd1;
  localparam logic [1:0] ORDER_MOTOROLA = 2'd2;

  localparam logic [5:0]  MAX_LEN = 6'd32;
  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  // One input word as it is held by the front end.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  slot;
    logic        slot_enable;
    logic [10:0] frame_id;
    logic [63:0] payload;
    logic [5:0]  field_start;
    logic [5:0]  bit_length;
    logic [1:0]  bit_order;
    logic        signed_field;
    logic [31:0] scale;
    logic [47:0] offset;
    logic [32:0] invalid_limit;
  } item_t;

  // One signal slot definition. Start is linear MSB0 or LSB0, length clamped.
  typedef struct packed {
    logic [10:0] match_id;
    logic [5:0]  start;
    logic [5:0]  length;
    logic        lsb_first;
    logic        signed_field;
    logic [31:0] scale;
    logic [47:0] offset;
    logic [32:0] limit;
  } slot_cfg_t;

  // A matched frame waiting for the back end.
  typedef struct packed {
    logic [63:0]            payload;
    logic [NUM_STREAMS-1:0] mask;
    logic [31:0]            timestamp;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

FILE: sv/can_signal_stream_decoder.sv
// The front end holds one word at a time and takes the next only once it is done with it.
// A frame stalls only on a full queue. A matched frame is pushed into the queue and popped
// by an idle back end, which walks its slots through stage one, stage two and the one-deep
// hold to the output register, at most one result a cycle; results cannot stall. A slot
// write waits until the queue is empty and no frame is walked or in stage one or two.
// Reset (asynchronous, active low) disables all slots and clears time, queue and strobe.
`default_nettype none

module can_signal_stream_decoder
  import csd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [2:0]         slot_i,
  input  wire logic               slot_enable_i,
  input  wire logic [10:0]        frame_id_i,
  input  wire logic [63:0]        payload_i,
  input  wire logic [5:0]         field_start_i,
  input  wire logic [5:0]         bit_length_i,
  input  wire logic [1:0]         bit_order_i,
  input  wire logic               signed_field_i,
  input  wire logic signed [31:0] scale_i,
  input  wire logic signed [47:0] offset_i,
  input  wire logic [32:0]        invalid_limit_i,
  output logic                    strobe_o,
  output logic [2:0]              slot_index_o,
  output logic signed [63:0]      value_o,
  output logic [31:0]             timestamp_o,
  output logic                    last_o
);

  item_t              item;
  logic               back_idle;
  fifo_status_t       fifo_st;
  logic               push;
  frame_t             push_data;
  logic               pop;
  frame_t             head;
  logic [SLOT_IW-1:0] rd_idx;
  slot_cfg_t          rd_cfg;
  logic [SLOT_IW-1:0] out_idx;
  logic [63:0]        out_val;

  always_comb begin
    item.cmd           = cmd_i;
    item.slot          = slot_i;
    item.slot_enable   = slot_enable_i;
    item.frame_id      = frame_id_i;
    item.payload       = payload_i;
    item.field_start   = field_start_i;
    item.bit_length    = bit_length_i;
    item.bit_order     = bit_order_i;
    item.signed_field  = signed_field_i;
    item.scale         = scale_i;
    item.offset        = offset_i;
    item.invalid_limit = invalid_limit_i;
  end

  csd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .item_i      (item),
    .back_idle_i (back_idle),
    .fifo_st_i   (fifo_st),
    .push_o      (push),
    .push_data_o (push_data),
    .rd_idx_i    (rd_idx),
    .rd_cfg_o    (rd_cfg)
  );

  csd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_st)
  );

  csd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_st_i   (fifo_st),
    .head_i      (head),
    .pop_o       (pop),
    .rd_idx_o    (rd_idx),
    .rd_cfg_i    (rd_cfg),
    .idle_o      (back_idle),
    .strobe_o    (strobe_o),
    .slot_idx_o  (out_idx),
    .value_o     (out_val),
    .timestamp_o (timestamp_o),
    .last_o      (last_o)
  );

  assign slot_index_o = 3'(out_idx);
  assign value_o      = $signed(out_val);

endmodule

`default_nettype wire

FILE: sv/csd_front.sv
// ----------------------------------------------------------------------------
// CAN signal stream decoder front end
// Holds one word, applies slot writes and ticks, and queues matched frames.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_front
  import csd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire item_t                  item_i,
  input  wire logic                   back_idle_i,
  input  wire fifo_status_t           fifo_st_i,
  output logic                        push_o,
  output frame_t                      push_data_o,
  input  wire logic [SLOT_IW-1:0]     rd_idx_i,
  output slot_cfg_t                   rd_cfg_o
);

  logic                   item_valid_q, item_valid_d;
  item_t                  item_q;
  logic [NUM_STREAMS-1:0] slot_valid_q, slot_valid_d;
  slot_cfg_t              slot_tab_q [NUM_STREAMS];
  logic [31:0]            tick_q, tick_d;

  logic                   accept;
  logic                   done;
  logic                   do_write;
  logic                   do_tick;
  logic [NUM_STREAMS-1:0] match;
  logic [SLOT_IW-1:0]     wr_idx;
  logic                   wr_in_range;
  slot_cfg_t              wr_cfg;

  assign accept = start_i && !item_valid_q;
  assign busy_o = item_valid_q;

  always_comb begin
    for (int k = 0; k < NUM_STREAMS; k++) begin
      match[k] = slot_valid_q[k] && (slot_tab_q[k].match_id == item_q.frame_id);
    end
  end

  always_comb begin
    done     = 1'b0;
    do_write = 1'b0;
    do_tick  = 1'b0;
    push_o   = 1'b0;
    if (item_valid_q) begin
      unique case (item_q.cmd)
        CMD_WRITE: begin
          // A slot may only change once no earlier frame can still read it.
          if (back_idle_i && fifo_st_i.empty) begin
            do_write = 1'b1;
            done     = 1'b1;
          end
        end
        CMD_FRAME: begin
          if (match == '0) begin
            done = 1'b1;
          end else if (!fifo_st_i.full) begin
            push_o = 1'b1;
            done   = 1'b1;
          end
        end
        CMD_TICK: begin
          do_tick = 1'b1;
          done    = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign push_data_o.payload   = item_q.payload;
  assign push_data_o.mask      = match;
  assign push_data_o.timestamp = tick_q;

  assign wr_idx      = SLOT_IW'(item_q.slot);
  assign wr_in_range = 32'(item_q.slot) < NUM_STREAMS;

  always_comb begin
    wr_cfg.match_id  = item_q.frame_id;
    // Motorola numbering flips the bit within its byte.
    if (item_q.bit_order == ORDER_MOTOROLA) begin
      wr_cfg.start = {item_q.field_start[5:3], 3'd7 - item_q.field_start[2:0]};
    end else begin
      wr_cfg.start = item_q.field_start;
    end
    wr_cfg.length    = (item_q.bit_length > MAX_LEN) ? MAX_LEN : item_q.bit_length;
    wr_cfg.lsb_first = (item_q.bit_order == ORDER_LSB0);
    wr_cfg.signed_field = item_q.signed_field;
    wr_cfg.scale     = item_q.scale;
    wr_cfg.offset    = item_q.offset;
    wr_cfg.limit     = item_q.invalid_limit;
  end

  always_comb begin
    item_valid_d = item_valid_q;
    if (done) begin
      item_valid_d = 1'b0;
    end
    if (accept) begin
      item_valid_d = 1'b1;
    end
    slot_valid_d = slot_valid_q;
    if (do_write && wr_in_range) begin
      slot_valid_d[wr_idx] = item_q.slot_enable;
    end
    tick_d = do_tick ? tick_q + 32'd1 : tick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      slot_valid_q <= '0;
      tick_q       <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      slot_valid_q <= slot_valid_d;
      tick_q       <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (do_write && wr_in_range) begin
      slot_tab_q[wr_idx] <= wr_cfg;
    end
  end

  assign rd_cfg_o = slot_tab_q[rd_idx_i];

endmodule

`default_nettype wire

FILE: sv/csd_fifo.sv
// ----------------------------------------------------------------------------
// CAN signal stream decoder frame queue
// Short queue of matched frames between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_fifo
  import csd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t push_data_i,
  input  wire logic   pop_i,
  output frame_t      head_o,
  output fifo_status_t status_o
);

  frame_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  logic do_push;
  logic do_pop;

  assign status_o.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: sv/csd_back.sv
// ----------------------------------------------------------------------------
// CAN signal stream decoder back end
// Walks the matched slots of a frame, extracts, scales and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_back
  import csd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fifo_status_t       fifo_st_i,
  input  wire frame_t             head_i,
  output logic                    pop_o,
  output logic [SLOT_IW-1:0]      rd_idx_o,
  input  wire slot_cfg_t          rd_cfg_i,
  output logic                    idle_o,
  output logic                    strobe_o,
  output logic [SLOT_IW-1:0]      slot_idx_o,
  output logic [63:0]             value_o,
  output logic [31:0]             timestamp_o,
  output logic                    last_o
);

  // Current frame being walked.
  logic                   cur_valid_q, cur_valid_d;
  logic [NUM_STREAMS-1:0] cur_mask_q, cur_mask_d;
  logic [63:0]            cur_payload_q;
  logic [31:0]            cur_ts_q;

  // Slot pick.
  logic [SLOT_IW-1:0]     pick;
  logic [NUM_STREAMS-1:0] remain;
  logic                   issue;
  logic                   eof;

  // Field extraction.
  logic [63:0]        swapped;
  logic [95:0]        msb_sh;
  logic [95:0]        lsb_sh;
  logic [31:0]        len_mask;
  logic [31:0]        raw;
  logic [4:0]         sign_pos;
  logic signed [32:0] sraw;
  logic               keep;

  // Stage one: raw value registered.
  logic               s1_valid_q;
  logic               s1_keep_q, s1_eof_q;
  logic [SLOT_IW-1:0] s1_idx_q;
  logic signed [32:0] s1_sraw_q;
  logic signed [31:0] s1_scale_q;
  logic [47:0]        s1_off_q;
  logic [31:0]        s1_ts_q;

  // Stage two: product registered.
  logic signed [64:0] prod_full;
  logic               s2_valid_q;
  logic               s2_keep_q, s2_eof_q;
  logic [SLOT_IW-1:0] s2_idx_q;
  logic [63:0]        s2_prod_q;
  logic [47:0]        s2_off_q;
  logic [31:0]        s2_ts_q;

  // Offset add and saturation, then a one-deep hold so that last is known.
  logic [64:0]        sum;
  logic [63:0]        sat;
  logic               pend_valid_q, pend_valid_d;
  logic               pend_final_q, pend_final_d;
  logic [SLOT_IW-1:0] pend_idx_q;
  logic [63:0]        pend_val_q;
  logic [31:0]        pend_ts_q;
  logic               pend_load;
  logic               emit;
  logic               emit_last;

  logic               strobe_q;
  logic               last_q;
  logic [SLOT_IW-1:0] out_idx_q;
  logic [63:0]        out_val_q;
  logic [31:0]        out_ts_q;

  // Lowest pending slot first, matching slot order.
  always_comb begin
    pick = '0;
    for (int k = NUM_STREAMS - 1; k >= 0; k--) begin
      if (cur_mask_q[k]) begin
        pick = SLOT_IW'(k);
      end
    end
  end

  always_comb begin
    remain       = cur_mask_q;
    remain[pick] = 1'b0;
  end

  assign issue = cur_valid_q;
  assign eof   = (remain == '0);
  assign pop_o = !cur_valid_q && !fifo_st_i.empty;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_mask_d  = cur_mask_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      cur_mask_d  = head_i.mask;
    end else if (issue) begin
      cur_mask_d = remain;
      if (eof) begin
        cur_valid_d = 1'b0;
      end
    end
  end

  assign rd_idx_o = pick;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      swapped[8*i +: 8] = cur_payload_q[56 - 8*i +: 8];
    end
  end

  always_comb begin
    len_mask = ~(32'hFFFF_FFFF << rd_cfg_i.length);
    // MSB0: bit p sits at payload bit 63-p; zeros past the end of the payload.
    msb_sh   = {cur_payload_q, 32'h0} << rd_cfg_i.start;
    // LSB0: bit p sits at bit p of the byte-swapped payload.
    lsb_sh   = {32'h0, swapped} >> rd_cfg_i.start;
    if (rd_cfg_i.lsb_first) begin
      raw = lsb_sh[31:0] & len_mask;
    end else begin
      raw = msb_sh[95:64] >> (MAX_LEN - rd_cfg_i.length);
    end
    sign_pos = 5'(rd_cfg_i.length - 6'd1);
    if (rd_cfg_i.signed_field && (rd_cfg_i.length != '0) && raw[sign_pos]) begin
      sraw = $signed({1'b1, raw | ~len_mask});
    end else begin
      sraw = $signed({1'b0, raw});
    end
    keep = ({1'b0, raw} < rd_cfg_i.limit);
  end

  assign prod_full = s1_sraw_q * s1_scale_q;

  always_comb begin
    sum = {s2_prod_q[63], s2_prod_q} + {{17{s2_off_q[47]}}, s2_off_q};
    if (sum[64] != sum[63]) begin
      sat = sum[64] ? VAL_MIN : VAL_MAX;
    end else begin
      sat = sum[63:0];
    end
  end

  // A held result goes out when the next kept result of its frame shows up,
  // or marked last when the frame's final slot has passed.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_final_d = pend_final_q;
    pend_load    = 1'b0;
    emit         = 1'b0;
    emit_last    = 1'b0;
    priority if (pend_valid_q && pend_final_q) begin
      emit         = 1'b1;
      emit_last    = 1'b1;
      pend_valid_d = 1'b0;
      pend_final_d = 1'b0;
    end else if (s2_valid_q && s2_keep_q) begin
      emit         = pend_valid_q;
      pend_load    = 1'b1;
      pend_valid_d = 1'b1;
      pend_final_d = s2_eof_q;
    end else if (s2_valid_q && s2_eof_q) begin
      emit         = pend_valid_q;
      emit_last    = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      cur_mask_q   <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_final_q <= 1'b0;
      strobe_q     <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      cur_valid_q  <= cur_valid_d;
      cur_mask_q   <= cur_mask_d;
      s1_valid_q   <= issue;
      s2_valid_q   <= s1_valid_q;
      pend_valid_q <= pend_valid_d;
      pend_final_q <= pend_final_d;
      strobe_q     <= emit;
      last_q       <= emit && emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_payload_q <= head_i.payload;
      cur_ts_q      <= head_i.timestamp;
    end
    if (issue) begin
      s1_keep_q  <= keep;
      s1_eof_q   <= eof;
      s1_idx_q   <= pick;
      s1_sraw_q  <= sraw;
      s1_scale_q <= $signed(rd_cfg_i.scale);
      s1_off_q   <= rd_cfg_i.offset;
      s1_ts_q    <= cur_ts_q;
    end
    if (s1_valid_q) begin
      s2_keep_q <= s1_keep_q;
      s2_eof_q  <= s1_eof_q;
      s2_idx_q  <= s1_idx_q;
      s2_prod_q <= prod_full[63:0];
      s2_off_q  <= s1_off_q;
      s2_ts_q   <= s1_ts_q;
    end
    if (pend_load) begin
      pend_idx_q <= s2_idx_q;
      pend_val_q <= sat;
      pend_ts_q  <= s2_ts_q;
    end
    if (emit) begin
      out_idx_q <= pend_idx_q;
      out_val_q <= pend_val_q;
      out_ts_q  <= pend_ts_q;
    end
  end

  assign idle_o      = !cur_valid_q && !s1_valid_q && !s2_valid_q;
  assign strobe_o    = strobe_q;
  assign last_o      = last_q;
  assign slot_idx_o  = out_idx_q;
  assign value_o     = out_val_q;
  assign timestamp_o = out_ts_q;

endmodule

`default_nettype wire

FILE: sv/csd_checker.sv
// ----------------------------------------------------------------------------
// CAN signal stream decoder port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_signal_stream_decoder_macros.svh"

module csd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        strobe_o,
  input wire logic [2:0]  slot_index_o,
  input wire logic [31:0] timestamp_o,
  input wire logic        last_o
);

  // Once reset has been seen at an edge, nothing comes out and nothing is held.
  `CSD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!strobe_o && !busy), "output active in reset")

  // A taken word occupies the front end for at least the following cycle.
  `CSD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "word taken but not held")

  // Back-to-back words of one frame come in rising slot order.
  `CSD_ASSERT(a_slot_order, (strobe_o && !last_o) |=> (!strobe_o || (slot_index_o > $past(slot_index_o))), "slot order broken")

  // Back-to-back words of one frame carry the same time.
  `CSD_ASSERT(a_same_time, (strobe_o && !last_o) |=> (!strobe_o || (timestamp_o == $past(timestamp_o))), "time changed within frame")

endmodule

bind can_signal_stream_decoder csd_checker u_csd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .strobe_o     (strobe_o),
  .slot_index_o (slot_index_o),
  .timestamp_o  (timestamp_o),
  .last_o       (last_o)
);

`default_nettype wire

FILE: verif/can_signal_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN signal stream decoder testbench
// Sends slot writes, ticks, frames and unused commands through the command port,
// predicts the decoded signal words in a scoreboard and checks every strobed result.
// ----------------------------------------------------------------------------

module testbench;
  import csd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [1:0]  ORDER_MSB0  = 2'd0;
  localparam logic [1:0]  ORDER_SPARE = 2'd3;
  localparam logic [31:0] SCALE_ONE   = 32'h0001_0000;
  localparam logic [31:0] SCALE_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] SCALE_MIN   = 32'h8000_0000;
  localparam logic [47:0] OFFSET_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OFFSET_MIN  = 48'h8000_0000_0000;
  localparam logic [32:0] LIMIT_OFF   = 33'h1_0000_0000;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic [63:0] value;
    logic [31:0] timestamp;
    logic        last;
  } signal_word_t;

  class signal_scoreboard;
    bit           active[NUM_STREAMS];
    bit [10:0]    match_id[NUM_STREAMS];
    bit [5:0]     first_bit[NUM_STREAMS];
    bit [5:0]     field_len[NUM_STREAMS];
    bit           lsb_first[NUM_STREAMS];
    bit           signed_field[NUM_STREAMS];
    longint       gain[NUM_STREAMS];
    longint       bias[NUM_STREAMS];
    bit [32:0]    drop_limit[NUM_STREAMS];
    bit [31:0]    tick_count;
    signal_word_t decoded_q[$];
    int unsigned  mismatches;

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    function void note_word(item_t w);
      signal_word_t hits[$];
      signal_word_t hit;
      int unsigned  s, len, pos, phys;
      bit [63:0]    raw;
      bit           bitv;
      longint       sraw, prod;
      logic [64:0]  sum;
      case (w.cmd)
        CMD_WRITE: begin
          s = w.slot;
          first_bit[s] = w.field_start;
          // Motorola start bits count from the LSB of a byte; keep them as MSB0.
          if (w.bit_order == ORDER_MOTOROLA) begin
            first_bit[s] = {w.field_start[5:3], 3'd7 - w.field_start[2:0]};
          end
          active[s]     = w.slot_enable;
          match_id[s]   = w.frame_id;
          field_len[s]  = w.bit_length;
          lsb_first[s]  = (w.bit_order == ORDER_LSB0);
          signed_field[s] = w.signed_field;
          gain[s]       = $signed(w.scale);
          bias[s]       = $signed(w.offset);
          drop_limit[s] = w.invalid_limit;
        end
        CMD_TICK: begin
          tick_count++;
        end
        CMD_FRAME: begin
          for (int k = 0; k < NUM_STREAMS; k++) begin
            if (!active[k] || match_id[k] != w.frame_id) continue;
            len = (field_len[k] > MAX_LEN) ? MAX_LEN : field_len[k];
            raw = '0;
            for (int b = 0; b < len; b++) begin
              pos  = first_bit[k] + b;
              bitv = 1'b0;
              if (pos <= 63) begin
                phys = lsb_first[k] ? 56 - 8 * (pos / 8) + pos % 8 : 63 - pos;
                bitv = w.payload[phys];
              end
              if (lsb_first[k]) raw[b] = bitv;
              else raw = {raw[62:0], bitv};
            end
            // The drop test looks at the unsigned field, before sign extension.
            if (raw >= {31'b0, drop_limit[k]}) continue;
            sraw = longint'(raw);
            if (signed_field[k] && len > 0 && raw[len-1]) sraw = sraw - (longint'(1) << len);
            prod = sraw * gain[k];
            sum  = {prod[63], prod} + {bias[k][63], bias[k]};
            hit.slot_index = k[2:0];
            hit.value      = (sum[64] != sum[63]) ? (sum[64] ? VAL_MIN : VAL_MAX) : sum[63:0];
            hit.timestamp  = tick_count;
            hit.last       = 1'b0;
            hits.push_back(hit);
          end
          if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
          foreach (hits[i]) decoded_q.push_back(hits[i]);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
      $display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got_v, want_v);
      mismatches++;
    endtask

    task check_result(signal_word_t got);
      signal_word_t want;
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing outstanding, slot", got.slot_index, 0);
        return;
      end
      want = decoded_q.pop_front();
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", got.slot_index, want.slot_index);
      if (got.value !== want.value) report_mismatch("value", got.value, want.value);
      if (got.timestamp !== want.timestamp)
        report_mismatch("timestamp", got.timestamp, want.timestamp);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  item_t               word = '0;
  logic                strobe_o;
  logic [2:0]          slot_index_o;
  logic signed [63:0]  value_o;
  logic [31:0]         timestamp_o;
  logic                last_o;
  int unsigned         cycle_count = 0;
  logic [10:0]         id_pool[4];
  signal_scoreboard    sb = new();

  can_signal_stream_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (word.cmd),
    .slot_i          (word.slot),
    .slot_enable_i   (word.slot_enable),
    .frame_id_i      (word.frame_id),
    .payload_i       (word.payload),
    .field_start_i   (word.field_start),
    .bit_length_i    (word.bit_length),
    .bit_order_i     (word.bit_order),
    .signed_field_i  (word.signed_field),
    .scale_i         (word.scale),
    .offset_i        (word.offset),
    .invalid_limit_i (word.invalid_limit),
    .strobe_o        (strobe_o),
    .slot_index_o    (slot_index_o),
    .value_o         (value_o),
    .timestamp_o     (timestamp_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Inputs change only by nonblocking updates, so this sees the values before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_word(word);
      if (strobe_o) sb.check_result(signal_word_t'{slot_index_o, value_o, timestamp_o, last_o});
    end
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic item_t random_fill();
    logic [223:0] fill;
    fill = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return item_t'(fill[$bits(item_t)-1:0]);
  endfunction

  function automatic item_t make_write(logic [2:0] s, logic en, logic [10:0] id,
                                       logic [5:0] first, logic [5:0] len,
                                       logic [1:0] order, logic sgn, logic [31:0] gain,
                                       logic [47:0] bias, logic [32:0] limit);
    item_t w;
    w = random_fill();
    w.cmd           = CMD_WRITE;
    w.slot          = s;
    w.slot_enable   = en;
    w.frame_id      = id;
    w.field_start   = first;
    w.bit_length    = len;
    w.bit_order     = order;
    w.signed_field  = sgn;
    w.scale         = gain;
    w.offset        = bias;
    w.invalid_limit = limit;
    return w;
  endfunction

  function automatic item_t make_frame(logic [10:0] id, logic [63:0] data);
    item_t w;
    w = random_fill();
    w.cmd      = CMD_FRAME;
    w.frame_id = id;
    w.payload  = data;
    return w;
  endfunction

  function automatic item_t make_plain(logic [1:0] c);
    item_t w;
    w = random_fill();
    w.cmd = c;
    return w;
  endfunction

  task automatic drive_word(item_t w);
    word  <= w;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_phase(int unsigned count, int unsigned idle_pct);
    item_t       w;
    int unsigned done_count;
    int unsigned pick;
    done_count = 0;
    while (done_count < count) begin
      w    = random_fill();
      pick = $urandom_range(99);
      if (pick < 14) begin
        w.cmd = CMD_WRITE;
        if ($urandom_range(9) != 0) w.frame_id = id_pool[$urandom_range(3)];
        w.slot_enable = ($urandom_range(9) < 8);
        case ($urandom_range(9))
          0: w.bit_length = 6'd0;
          1: w.bit_length = 6'($urandom_range(63, 33));
          2: w.bit_length = MAX_LEN;
          default: w.bit_length = 6'($urandom_range(32, 1));
        endcase
        case ($urandom_range(9))
          0: w.scale = SCALE_MAX;
          1: w.scale = SCALE_MIN;
          2: w.scale = SCALE_ONE;
          default: ;
        endcase
        if ($urandom_range(9) == 0) w.offset = $urandom_range(1) ? OFFSET_MAX : OFFSET_MIN;
        case ($urandom_range(7))
          0, 1, 2: w.invalid_limit = LIMIT_OFF;
          3: w.invalid_limit[32] = 1'b1;
          4: w.invalid_limit = 33'($urandom_range(255));
          default: w.invalid_limit[32] = 1'b0;
        endcase
      end else if (pick < 24) begin
        w.cmd = CMD_TICK;
      end else if (pick < 27) begin
        w.cmd = CMD_UNUSED;
      end else begin
        w.cmd = CMD_FRAME;
        if ($urandom_range(99) < 85) w.frame_id = id_pool[$urandom_range(3)];
        case ($urandom_range(19))
          0: w.payload = '1;
          1: w.payload = '0;
          default: ;
        endcase
      end
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      drive_word(w);
      // The unused command is ignored by the block and does not count.
      if (w.cmd != CMD_UNUSED) done_count++;
    end
  endtask

  initial begin
    id_pool[0] = 11'h7FF;
    id_pool[1] = 11'h000;
    id_pool[2] = 11'($urandom);
    id_pool[3] = 11'($urandom);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_word(make_plain(CMD_TICK));
    drive_word(make_plain(CMD_TICK));
    drive_word(make_write(3'd0, 1'b1, 11'h123, 6'd0, 6'd8, ORDER_MSB0, 1'b0,
                          SCALE_ONE, 48'd0, LIMIT_OFF));
    // Little endian field that runs past the last payload bit.
    drive_word(make_write(3'd1, 1'b1, 11'h123, 6'd60, 6'd32, ORDER_LSB0, 1'b1,
                          32'hFFFF_FFFF, OFFSET_MAX, LIMIT_OFF));
    // Full-width unsigned Motorola field with the most negative gain and offset.
    drive_word(make_write(3'd2, 1'b1, 11'h123, 6'd7, 6'd32, ORDER_MOTOROLA, 1'b0,
                          SCALE_MIN, OFFSET_MIN, LIMIT_OFF));
    // Spare bit order and an over-long length, pushed into positive saturation.
    drive_word(make_write(3'd3, 1'b1, 11'h123, 6'd32, 6'd63, ORDER_SPARE, 1'b0,
                          SCALE_MAX, OFFSET_MAX, 33'h1_FFFF_FFFF));
    drive_word(make_write(3'd4, 1'b1, 11'h123, 6'd17, 6'd0, ORDER_LSB0, 1'b1,
                          32'h1234_5678, OFFSET_MIN, 33'd1));
    drive_word(make_write(3'd5, 1'b1, 11'h7FF, 6'd56, 6'd8, ORDER_MSB0, 1'b0,
                          SCALE_ONE, 48'd7, 33'd5));
    drive_word(make_write(3'd6, 1'b0, 11'h123, 6'd0, 6'd8, ORDER_MSB0, 1'b0,
                          SCALE_ONE, 48'd0, LIMIT_OFF));
    // Signed full-width field whose drop limit applies to the unsigned pattern.
    drive_word(make_write(3'd7, 1'b1, 11'h123, 6'd32, 6'd32, ORDER_MSB0, 1'b1,
                          SCALE_ONE, 48'd0, 33'h0_8000_0000));
    drive_word(make_frame(11'h123, '1));
    drive_word(make_frame(11'h123, '0));
    drive_word(make_frame(11'h123, 64'h0123_4567_89AB_CDEF));
    drive_word(make_frame(11'h123, 64'h8000_0000_7FFF_FFFF));
    drive_word(make_frame(11'h7FF, 64'h0000_0000_0000_0003));
    drive_word(make_frame(11'h7FF, 64'h0000_0000_0000_00C8));
    drive_word(make_frame(11'h000, {$urandom, $urandom}));
    drive_word(make_plain(CMD_UNUSED));
    drive_word(make_plain(CMD_TICK));
    drive_word(make_write(3'd6, 1'b1, 11'h000, 6'd0, 6'd1, ORDER_MOTOROLA, 1'b1,
                          SCALE_ONE, 48'd0, LIMIT_OFF));
    drive_word(make_frame(11'h000, '1));
    drive_word(make_frame(11'h123, {$urandom, $urandom}));

    // Hold the sender off until the decoder has answered everything.
    wait_drained();
    run_phase(82, 0);
    wait_drained();
    run_phase(82, 82);
    wait_drained();
    run_phase(82, 20);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/csd_pkg.sv
sv/csd_front.sv
sv/csd_fifo.sv
sv/csd_back.sv
sv/can_signal_stream_decoder.sv
sv/csd_checker.sv
verif/can_signal_stream_decoder_tb.sv
